@@ design/hcfh_pkg.sv @@
// Shared types and constants for the host command frame handler.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package hcfh_pkg;

  // Frame byte values
  localparam logic [7:0] END_BYTE  = 8'hA5;
  localparam logic [7:0] MARK_BYTE = 8'hAA;

  // Command codes found at the command position of a frame
  localparam logic [7:0] CMD_LINK0 = 8'h00;
  localparam logic [7:0] CMD_LINK1 = 8'h01;
  localparam logic [7:0] CMD_START = 8'h02;
  localparam logic [7:0] CMD_STOP  = 8'h03;
  localparam logic [7:0] CMD_SET   = 8'h04;

  localparam logic signed [15:0] TARGET_RESET = 16'sd250;

  // Fixed store positions
  localparam int unsigned POS_FIRST     = 0;
  localparam int unsigned POS_CMD       = 2;
  localparam int unsigned POS_TEMP_HI   = 3;
  localparam int unsigned POS_TEMP_LO   = 4;
  localparam int unsigned POS_GAIN      = 5;
  localparam int unsigned POS_MARK_LAST = 9;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_SET,
    KIND_LINK,
    KIND_START,
    KIND_STOP
  } cmd_kind_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_RX,
    WR_TEMP_HI,
    WR_TEMP_LO,
    WR_MARK_FIRST,
    WR_MARK_LAST
  } wr_sel_e;

  typedef struct packed {
    logic    accept;
    wr_sel_e wr_sel;
    logic    load_set;
    logic    run_set;
    logic    run_clr;
    logic    rd_en;
    logic    rd_first;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic      rx_end;
    cmd_kind_e cmd_kind;
    logic      echo_last;
    logic      out_free;
  } stat_t;

endpackage

@@ design/hcfh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hcfh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/hcfh_ctrl.sv @@
// Controller state machine: input handshake, command sequencing, echo readout.
// Depends on hcfh_pkg.
`timescale 1ns / 1ps

module hcfh_ctrl import hcfh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EXEC    = 8'b0000_0010,
    ST_WR_HI   = 8'b0000_0100,
    ST_WR_LO   = 8'b0000_1000,
    ST_MK_FST  = 8'b0001_0000,
    ST_MK_LST  = 8'b0010_0000,
    ST_ECHO_RD = 8'b0100_0000,
    ST_ECHO_LD = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.wr_sel   = WR_NONE;
    s_ready_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctrl_o.accept = 1'b1;
          ctrl_o.wr_sel = WR_RX;
          if (stat_i.rx_end) begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        case (stat_i.cmd_kind)
          KIND_SET: begin
            ctrl_o.load_set = 1'b1;
            state_d = ST_ECHO_RD;
          end
          KIND_LINK: state_d = ST_WR_HI;
          KIND_START: begin
            ctrl_o.run_set = 1'b1;
            state_d = ST_WR_HI;
          end
          KIND_STOP: begin
            ctrl_o.run_clr = 1'b1;
            state_d = ST_WR_HI;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WR_HI: begin
        ctrl_o.wr_sel = WR_TEMP_HI;
        state_d = ST_WR_LO;
      end
      ST_WR_LO: begin
        ctrl_o.wr_sel = WR_TEMP_LO;
        state_d = (stat_i.cmd_kind == KIND_LINK) ? ST_MK_FST : ST_ECHO_RD;
      end
      ST_MK_FST: begin
        ctrl_o.wr_sel = WR_MARK_FIRST;
        state_d = ST_MK_LST;
      end
      ST_MK_LST: begin
        ctrl_o.wr_sel = WR_MARK_LAST;
        state_d = ST_ECHO_RD;
      end
      ST_ECHO_RD: begin
        ctrl_o.rd_en    = 1'b1;
        ctrl_o.rd_first = 1'b1;
        state_d = ST_ECHO_LD;
      end
      ST_ECHO_LD: begin
        // load one byte per free output slot, fetch the next one alongside
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          if (stat_i.echo_last) begin
            state_d = ST_IDLE;
          end else begin
            ctrl_o.rd_en = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/hcfh_datapath.sv @@
// Datapath: frame store, byte counter, settings registers and output register.
// Depends on hcfh_pkg and hcfh_ram.
`timescale 1ns / 1ps

module hcfh_datapath import hcfh_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic [7:0]         rx_byte_i,
  input  logic signed [15:0] current_temp_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_last_o,
  output logic [7:0]         tx_byte_o,
  output logic signed [15:0] target_o,
  output logic [7:0]         gain_o,
  output logic               run_o,
  output logic               indicator_o
);

  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic [IDX_W-1:0]       count_q;
  logic [15:0]            temp_q;
  logic signed [15:0]     target_q;
  logic [7:0]             gain_q;
  logic                   run_q;
  logic                   ind_q;
  logic [7:0]             sh_cmd_q, sh_hi_q, sh_lo_q, sh_gain_q;
  logic [FRAME_BYTES-1:0] valid_q;
  logic [IDX_W-1:0]       echo_idx_q;
  logic                   rvalid_q;
  logic [IDX_W-1:0]       rd_addr;
  logic [7:0]             rdata;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [7:0]             wdata;
  logic                   out_valid_q;
  logic                   out_last_q;
  logic [7:0]             tx_byte_q;
  logic signed [15:0]     target_out_q;
  logic [7:0]             gain_out_q;
  logic                   run_out_q;
  logic                   ind_out_q;

  // write port select
  always_comb begin
    we    = 1'b1;
    waddr = count_q;
    wdata = rx_byte_i;
    case (ctrl_i.wr_sel)
      WR_RX: begin
        waddr = count_q;
        wdata = rx_byte_i;
      end
      WR_TEMP_HI: begin
        waddr = IDX_W'(POS_TEMP_HI);
        wdata = temp_q[15:8];
      end
      WR_TEMP_LO: begin
        waddr = IDX_W'(POS_TEMP_LO);
        wdata = temp_q[7:0];
      end
      WR_MARK_FIRST: begin
        waddr = IDX_W'(POS_FIRST);
        wdata = MARK_BYTE;
      end
      WR_MARK_LAST: begin
        waddr = IDX_W'(POS_MARK_LAST);
        wdata = MARK_BYTE;
      end
      default: we = 1'b0;
    endcase
  end

  assign rd_addr = ctrl_i.rd_first ? '0 : echo_idx_q + 1'b1;

  hcfh_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // status flags and command decode
  always_comb begin
    stat_o.rx_end    = (rx_byte_i == END_BYTE);
    stat_o.echo_last = (echo_idx_q == LAST_IDX);
    stat_o.out_free  = !out_valid_q || out_ready_i;
    if (sh_cmd_q == CMD_SET) begin
      stat_o.cmd_kind = KIND_SET;
    end else if (sh_cmd_q inside {CMD_LINK0, CMD_LINK1}) begin
      stat_o.cmd_kind = KIND_LINK;
    end else if (sh_cmd_q == CMD_START) begin
      stat_o.cmd_kind = KIND_START;
    end else if (sh_cmd_q == CMD_STOP) begin
      stat_o.cmd_kind = KIND_STOP;
    end else begin
      stat_o.cmd_kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      target_q  <= TARGET_RESET;
      gain_q    <= '0;
      run_q     <= 1'b0;
      ind_q     <= 1'b0;
      sh_cmd_q  <= '0;
      sh_hi_q   <= '0;
      sh_lo_q   <= '0;
      sh_gain_q <= '0;
      valid_q   <= '0;
    end else begin
      if (ctrl_i.accept) begin
        if (stat_o.rx_end || count_q == LAST_IDX) begin
          count_q <= '0;
        end else begin
          count_q <= count_q + 1'b1;
        end
        if (stat_o.rx_end) begin
          ind_q <= ~ind_q;
        end
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
        // keep copies of the bytes the commands read
        if (waddr == IDX_W'(POS_CMD))     sh_cmd_q  <= wdata;
        if (waddr == IDX_W'(POS_TEMP_HI)) sh_hi_q   <= wdata;
        if (waddr == IDX_W'(POS_TEMP_LO)) sh_lo_q   <= wdata;
        if (waddr == IDX_W'(POS_GAIN))    sh_gain_q <= wdata;
      end
      if (ctrl_i.load_set) begin
        target_q <= {sh_hi_q, sh_lo_q};
        gain_q   <= sh_gain_q;
      end
      if (ctrl_i.run_set) begin
        run_q <= 1'b1;
      end else if (ctrl_i.run_clr) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      temp_q <= current_temp_i;
    end
    if (ctrl_i.rd_en) begin
      echo_idx_q <= rd_addr;
      rvalid_q   <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      // never-written entries read as zero
      tx_byte_q    <= rvalid_q ? rdata : 8'h00;
      out_last_q   <= stat_o.echo_last;
      target_out_q <= target_q;
      gain_out_q   <= gain_q;
      run_out_q    <= run_q;
      ind_out_q    <= ind_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign tx_byte_o   = tx_byte_q;
  assign target_o    = target_out_q;
  assign gain_o      = gain_out_q;
  assign run_o       = run_out_q;
  assign indicator_o = ind_out_q;

endmodule

@@ design/host_command_frame_handler_core.sv @@
// Top level of the host command frame handler: stream ports, controller and datapath.
// Depends on hcfh_pkg, hcfh_ctrl, hcfh_datapath (and hcfh_ram through it).
`timescale 1ns / 1ps

// Received bytes enter one per transaction and are written into a FRAME_BYTES-deep
// frame store; an ordinary byte leaves the block ready for the next one. A 0xA5
// byte ends the frame, toggles the indicator and runs the command held at store
// position 2. Known commands then echo the whole store, one transaction per byte
// in store order with tlast on the final byte; unknown commands echo nothing. From
// the end-byte transaction until the last echo byte is loaded into the output
// register the input is held off: set loads the settings, start and stop set or
// clear the run flag and write the temperature bytes, link writes the temperature
// and marker bytes, and an output stall holds the echo. The store is a single-write,
// registered-read RAM, so temperature and marker bytes are written one per cycle and
// the echo streams one byte per cycle when not stalled. The store reads as zero after
// reset through per-entry valid flags, so no clearing pass is needed.
module host_command_frame_handler_core import hcfh_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] rx_byte, [23:8] current_temp
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] tx_byte, [23:8] target_out,
                                        // [31:24] gain_out, [32] run_out,
                                        // [33] indicator_out, [39:34] zero
  output logic        m_axis_tlast_o    // last_of_run
);

  ctrl_t              ctrl;
  stat_t              stat;
  logic [7:0]         tx_byte;
  logic signed [15:0] target_out;
  logic [7:0]         gain_out;
  logic               run_out;
  logic               indicator_out;

  hcfh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  hcfh_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .rx_byte_i      (s_axis_tdata_i[7:0]),
    .current_temp_i (s_axis_tdata_i[23:8]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_last_o     (m_axis_tlast_o),
    .tx_byte_o      (tx_byte),
    .target_o       (target_out),
    .gain_o         (gain_out),
    .run_o          (run_out),
    .indicator_o    (indicator_out)
  );

  assign m_axis_tdata_o = {6'b0, indicator_out, run_out, gain_out, target_out, tx_byte};

  // ordinary bytes never stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[7:0] != END_BYTE)
      |=> s_axis_tready_o)
    else $error("input stalled after an ordinary byte");

  // a frame end always hands over to command execution
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[7:0] == END_BYTE)
      |=> !s_axis_tready_o)
    else $error("input still open right after a frame end");

  // the final echo load returns the block to accepting input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.out_load && stat.echo_last) |=> (s_axis_tready_o && m_axis_tvalid_o && m_axis_tlast_o))
    else $error("echo did not finish with tlast and reopen the input");

  // loads only happen into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten before its transaction");

endmodule
